// File: rtl/core/pcc_pkg.sv
// shared types, codes and constants for the pixel color conversion block
package pcc_pkg;

   localparam int COEF_FRAC_BITS_DEFAULT = 10;
   localparam int CHAN_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int MODE_W = 2;

   // luminosity weights in Q2.10, rescaled to other fraction widths
   localparam logic [31:0] LUMA_R_Q10 = 32'd306;
   localparam logic [31:0] LUMA_G_Q10 = 32'd601;
   localparam logic [31:0] LUMA_B_Q10 = 32'd117;
   localparam int Q10_FRAC = 10;

   // x / 3 as (x * 683) >> 11, exact for x below 1536
   localparam int AVG_SUM_W = CHAN_W + 2;
   localparam logic [AVG_SUM_W-1:0] AVG_RECIP = AVG_SUM_W'(683);
   localparam int AVG_SHIFT = 11;
   localparam int AVG_PROD_W = 2 * AVG_SUM_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_MATRIX  = 2'd0,
      MODE_AVERAGE = 2'd1,
      MODE_LIGHT   = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE      = 3'd0,
      CSR_ROW_RED   = 3'd1,
      CSR_ROW_GREEN = 3'd2,
      CSR_ROW_BLUE  = 3'd3
   } csr_index_type;

   // per-stage advance strobes shared by the datapath modules
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } adv_type;

   function automatic logic [31:0] scale_q10(input int frac, input logic [31:0] q10);
      logic [31:0] res;
      if (frac >= Q10_FRAC) begin
         res = q10 << (frac - Q10_FRAC);
      end else begin
         res = q10 >> (Q10_FRAC - frac);
      end
      return res;
   endfunction

endpackage

// File: rtl/core/pcc_channel.sv
// one output channel of the color matrix: products, sum, shift and saturate
module pcc_channel import pcc_pkg::*; #(
   parameter int CoefFracBits = COEF_FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  adv_type                         adv,
   input  logic [3*(CoefFracBits+2)-1:0]   row,
   input  logic [CHAN_W-1:0]               red_in,
   input  logic [CHAN_W-1:0]               green_in,
   input  logic [CHAN_W-1:0]               blue_in,
   output logic [CHAN_W-1:0]               chan_out
);

   localparam int CoefW = CoefFracBits + 2;
   localparam int ProdW = CoefW + CHAN_W;
   localparam int SumW = ProdW + 2;
   localparam int ShW = SumW - CoefFracBits;
   localparam logic [ShW-1:0] ChanMax = ShW'((1 << CHAN_W) - 1);

   logic [ProdW-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic [SumW-1:0]  sum_ff, sum_in;
   logic [ShW-1:0]   shifted;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   // stage 1: three narrow products
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_r_ff <= ProdW'(row[CoefW-1:0])         * ProdW'(red_in);
         prod_g_ff <= ProdW'(row[2*CoefW-1:CoefW])   * ProdW'(green_in);
         prod_b_ff <= ProdW'(row[3*CoefW-1:2*CoefW]) * ProdW'(blue_in);
      end
   end

   // stage 2: exact sum
   assign sum_in = SumW'(prod_r_ff) + SumW'(prod_g_ff) + SumW'(prod_b_ff);

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         sum_ff <= sum_in;
      end
   end

   // stage 3: drop fraction, clamp at full scale
   assign shifted = sum_ff[SumW-1:CoefFracBits];
   assign chan_in = (shifted > ChanMax) ? ChanMax[CHAN_W-1:0] : shifted[CHAN_W-1:0];

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         chan_ff <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

// File: rtl/core/pixel_colour_conversion.sv
// top level of the pixel color conversion block: csr, pipeline control, grey paths
//
// channel | ports                                        | direction
// req     | req_valid req_stall req_{red,green,blue}_in   | pixel in
// rsp     | rsp_valid rsp_stall rsp_{red,green,blue}_out  | pixel out
// csr     | csr_valid csr_ready csr_index csr_wdata       | register write
//
// three register stages, one pixel per cycle sustained while rsp_stall is low
// stage 1 multiplies (twelve by eight bits), stage 2 adds, stage 3 saturates
// a stage loads when it is empty or the stage after it can load, so bubbles close
// reset is synchronous, active high, clears valid bits, selects matrix mode and loads the luminosity rows
// csr writes are always accepted, as csr_ready is tied high; indexes above the row list are dropped
module pixel_colour_conversion import pcc_pkg::*; #(
   parameter int CoefFracBits = COEF_FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [CHAN_W-1:0]                req_red_in,
   input  logic [CHAN_W-1:0]                req_green_in,
   input  logic [CHAN_W-1:0]                req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [CHAN_W-1:0]                rsp_red_out,
   output logic [CHAN_W-1:0]                rsp_green_out,
   output logic [CHAN_W-1:0]                rsp_blue_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_W-1:0]           csr_index,
   input  logic [3*(CoefFracBits+2)-1:0]    csr_wdata
);

   localparam int CoefW = CoefFracBits + 2;
   localparam int RowW = 3 * CoefW;
   localparam logic [CoefW-1:0] RstR = CoefW'(scale_q10(CoefFracBits, LUMA_R_Q10));
   localparam logic [CoefW-1:0] RstG = CoefW'(scale_q10(CoefFracBits, LUMA_G_Q10));
   localparam logic [CoefW-1:0] RstB = CoefW'(scale_q10(CoefFracBits, LUMA_B_Q10));
   localparam logic [RowW-1:0] RowRst = {RstB, RstG, RstR};

   // ---------------- configuration registers ----------------
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [RowW-1:0]   row_red_ff, row_red_in;
   logic [RowW-1:0]   row_green_ff, row_green_in;
   logic [RowW-1:0]   row_blue_ff, row_blue_in;
   logic              csr_xfer;

   assign csr_ready = 1'b1;
   assign csr_xfer = csr_valid & csr_ready;

   always_comb begin
      mode_in = mode_ff;
      row_red_in = row_red_ff;
      row_green_in = row_green_ff;
      row_blue_in = row_blue_ff;
      if (csr_xfer) begin
         unique case (csr_index)
            CSR_MODE:      mode_in = csr_wdata[MODE_W-1:0];
            CSR_ROW_RED:   row_red_in = csr_wdata;
            CSR_ROW_GREEN: row_green_in = csr_wdata;
            CSR_ROW_BLUE:  row_blue_in = csr_wdata;
            default:       mode_in = mode_ff;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MATRIX;
         row_red_ff <= RowRst;
         row_green_ff <= RowRst;
         row_blue_ff <= RowRst;
      end else begin
         mode_ff <= mode_in;
         row_red_ff <= row_red_in;
         row_green_ff <= row_green_in;
         row_blue_ff <= row_blue_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic    v1_ff, v2_ff, v3_ff;
   logic    v1_in, v2_in, v3_in;
   adv_type adv;
   logic    req_xfer;

   // a stage may load when it is empty or its content moves on
   assign adv.s3 = ~v3_ff | ~rsp_stall;
   assign adv.s2 = ~v2_ff | adv.s3;
   assign adv.s1 = ~v1_ff | adv.s2;

   assign req_stall = ~adv.s1;
   assign req_xfer = req_valid & ~req_stall;

   assign v1_in = adv.s1 ? req_valid : v1_ff;
   assign v2_in = adv.s2 ? v1_ff : v2_ff;
   assign v3_in = adv.s3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // ---------------- matrix channels ----------------
   logic [CHAN_W-1:0] mat_red, mat_green, mat_blue;

   pcc_channel #(.CoefFracBits(CoefFracBits)) u_chan_red (
      .clock    (clock),
      .adv      (adv),
      .row      (row_red_ff),
      .red_in   (req_red_in),
      .green_in (req_green_in),
      .blue_in  (req_blue_in),
      .chan_out (mat_red)
   );

   pcc_channel #(.CoefFracBits(CoefFracBits)) u_chan_green (
      .clock    (clock),
      .adv      (adv),
      .row      (row_green_ff),
      .red_in   (req_red_in),
      .green_in (req_green_in),
      .blue_in  (req_blue_in),
      .chan_out (mat_green)
   );

   pcc_channel #(.CoefFracBits(CoefFracBits)) u_chan_blue (
      .clock    (clock),
      .adv      (adv),
      .row      (row_blue_ff),
      .red_in   (req_red_in),
      .green_in (req_green_in),
      .blue_in  (req_blue_in),
      .chan_out (mat_blue)
   );

   // ---------------- grey paths ----------------
   // stage 1: channel sum for average, (max + min) / 2 for lightness
   logic [CHAN_W-1:0]    hi_rg, lo_rg, max_c, min_c;
   logic [CHAN_W:0]      light_sum;
   logic [AVG_SUM_W-1:0] avg_sum_ff, avg_sum_in;
   logic [CHAN_W-1:0]    light_s1_ff, light_s1_in;
   logic [MODE_W-1:0]    mode_s1_ff;

   assign hi_rg = (req_red_in > req_green_in) ? req_red_in : req_green_in;
   assign lo_rg = (req_red_in < req_green_in) ? req_red_in : req_green_in;
   assign max_c = (hi_rg > req_blue_in) ? hi_rg : req_blue_in;
   assign min_c = (lo_rg < req_blue_in) ? lo_rg : req_blue_in;
   assign light_sum = {1'b0, max_c} + {1'b0, min_c};
   assign light_s1_in = light_sum[CHAN_W:1];
   assign avg_sum_in = AVG_SUM_W'(req_red_in) + AVG_SUM_W'(req_green_in)
                     + AVG_SUM_W'(req_blue_in);

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         avg_sum_ff <= avg_sum_in;
         light_s1_ff <= light_s1_in;
         mode_s1_ff <= mode_ff;
      end
   end

   // stage 2: reciprocal multiply for the divide by three
   logic [AVG_PROD_W-1:0] avg_prod_ff;
   logic [CHAN_W-1:0]     light_s2_ff;
   logic [MODE_W-1:0]     mode_s2_ff;

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         avg_prod_ff <= AVG_PROD_W'(avg_sum_ff) * AVG_PROD_W'(AVG_RECIP);
         light_s2_ff <= light_s1_ff;
         mode_s2_ff <= mode_s1_ff;
      end
   end

   // stage 3: pick the grey value; mode 3 falls to lightness
   logic [CHAN_W-1:0] grey_ff, grey_in;
   logic              matrix_s3_ff;

   always_comb begin
      case (mode_s2_ff)
         MODE_AVERAGE: grey_in = avg_prod_ff[AVG_SHIFT+CHAN_W-1:AVG_SHIFT];
         default:      grey_in = light_s2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         grey_ff <= grey_in;
         matrix_s3_ff <= (mode_s2_ff == MODE_MATRIX);
      end
   end

   // ---------------- result transfer ----------------
   assign rsp_valid = v3_ff;
   assign rsp_red_out = matrix_s3_ff ? mat_red : grey_ff;
   assign rsp_green_out = matrix_s3_ff ? mat_green : grey_ff;
   assign rsp_blue_out = matrix_s3_ff ? mat_blue : grey_ff;

`ifndef ASSERT_OFF
   // full pipeline with a stalled result must push back on the input
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && rsp_stall) |-> req_stall)
      else $error("full pipeline did not stall input");

   // an accepted pixel always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> v1_ff)
      else $error("accepted pixel lost at stage 1");

   // grey modes put one value on all three channels
   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !matrix_s3_ff) |->
         (rsp_red_out == rsp_green_out && rsp_green_out == rsp_blue_out))
      else $error("grey result channels differ");

   // stage 2 keeps the pixel it holds while downstream is blocked
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && v3_ff && rsp_stall) |=> v2_ff)
      else $error("stage 2 pixel dropped under stall");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for pixel_colour_conversion: directed and random pixels checked against a predictor
module tb_top import pcc_pkg::*; ();

   localparam int FRAC  = COEF_FRAC_BITS_DEFAULT;
   localparam int COEF_W = FRAC + 2;
   localparam int ROW_W = 3 * COEF_W;
   localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};
   // cycles without any transfer before the run is declared hung
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int PIXELS_PER_PHASE = 100;

   // rows pack the R coefficient at the bottom, then G, then B
   localparam logic [ROW_W-1:0] LUMA_ROW =
      {COEF_W'(LUMA_B_Q10), COEF_W'(LUMA_G_Q10), COEF_W'(LUMA_R_Q10)};
   localparam logic [ROW_W-1:0] SEPIA_RED   = {COEF_W'(194), COEF_W'(787), COEF_W'(402)};
   localparam logic [ROW_W-1:0] SEPIA_GREEN = {COEF_W'(172), COEF_W'(702), COEF_W'(357)};
   localparam logic [ROW_W-1:0] SEPIA_BLUE  = {COEF_W'(134), COEF_W'(547), COEF_W'(279)};
   localparam logic [ROW_W-1:0] ROW_FULL    = {ROW_W{1'b1}};
   localparam logic [ROW_W-1:0] ROW_ZERO    = '0;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // slice f of a packed pixel, lowest first
   string field_name [3] = '{"blue", "green", "red"};

   logic clock;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CHAN_W-1:0] req_red_in = '0;
   logic [CHAN_W-1:0] req_green_in = '0;
   logic [CHAN_W-1:0] req_blue_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CHAN_W-1:0] rsp_red_out;
   logic [CHAN_W-1:0] rsp_green_out;
   logic [CHAN_W-1:0] rsp_blue_out;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [ROW_W-1:0]       csr_wdata = '0;

   // mirror of the block's registers, as after reset
   logic [MODE_W-1:0] mode_now = MODE_MATRIX;
   logic [ROW_W-1:0]  rows_now [3] = '{LUMA_ROW, LUMA_ROW, LUMA_ROW};

   pixel_type pending_pixels [$];     // waiting to be driven
   pixel_type predicted_pixels [$];   // converted pixels still owed by the block

   int  error_count = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;               // no idling on either side while set

   pixel_colour_conversion #(
      .CoefFracBits(FRAC)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one output channel: dot product with a row, truncated, clamped at full scale
   function automatic logic [CHAN_W-1:0] matrix_channel(input logic [ROW_W-1:0] row,
                                                        input pixel_type px);
      logic [COEF_W+CHAN_W+1:0] sum;
      logic [COEF_W+CHAN_W+1:0] scaled;
      sum = row[COEF_W-1:0] * px.red
          + row[2*COEF_W-1:COEF_W] * px.green
          + row[3*COEF_W-1:2*COEF_W] * px.blue;
      scaled = sum >> FRAC;
      return (scaled > CHAN_MAX) ? CHAN_MAX : CHAN_W'(scaled);
   endfunction

   // what the block should return for one pixel under the current registers
   function automatic pixel_type convert_pixel(input pixel_type px);
      pixel_type         res;
      logic [CHAN_W+1:0] total;
      logic [CHAN_W-1:0] hi;
      logic [CHAN_W-1:0] lo;
      logic [CHAN_W-1:0] grey;
      case (mode_now)
         MODE_MATRIX: begin
            res.red   = matrix_channel(rows_now[0], px);
            res.green = matrix_channel(rows_now[1], px);
            res.blue  = matrix_channel(rows_now[2], px);
         end
         MODE_AVERAGE: begin
            total = px.red + px.green + px.blue;
            grey = CHAN_W'(total / 3);
            res = {grey, grey, grey};
         end
         default: begin
            // lightness; the unused code behaves the same way
            hi = (px.red > px.green) ? px.red : px.green;
            hi = (hi > px.blue) ? hi : px.blue;
            lo = (px.red < px.green) ? px.red : px.green;
            lo = (lo < px.blue) ? lo : px.blue;
            grey = CHAN_W'(({1'b0, hi} + lo) >> 1);
            res = {grey, grey, grey};
         end
      endcase
      return res;
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic void queue_pixel(input int r, input int g, input int b);
      pending_pixels.push_back({CHAN_W'(r), CHAN_W'(g), CHAN_W'(b)});
   endfunction

   // a row drawn from the luminosity row, the green and blue sepia rows, the extremes and random coefficients
   function automatic logic [ROW_W-1:0] pick_row();
      case ($urandom_range(0, 5))
         0: return LUMA_ROW;
         1: return ($urandom_range(0, 1) != 0) ? SEPIA_GREEN : SEPIA_BLUE;
         2: return ROW_FULL;
         3: return ROW_ZERO;
         4: return ROW_W'({$urandom(), $urandom()});
         default: return {COEF_W'($urandom_range(0, 1100)), COEF_W'($urandom_range(0, 1100)),
                          COEF_W'($urandom_range(0, 1100))};
      endcase
   endfunction

   // one register write; the mirror follows at the transfer
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [ROW_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:      mode_now = data[MODE_W-1:0];
         CSR_ROW_RED:   rows_now[0] = data;
         CSR_ROW_GREEN: rows_now[1] = data;
         CSR_ROW_BLUE:  rows_now[2] = data;
         default: ;     // unmapped index, dropped by the block
      endcase
   endtask

   // mode goes in the low bits, junk above them must be ignored
   task automatic write_mode(input logic [MODE_W-1:0] m);
      logic [ROW_W-1:0] value;
      value = ROW_W'({$urandom(), $urandom()});
      value[MODE_W-1:0] = m;
      write_reg(CSR_MODE, value);
   endtask

   // wait until every queued pixel went in and every result came back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || predicted_pixels.size() != 0);
      // pipeline is three deep, leave it a little margin
      repeat (4) @(negedge clock);
   endtask

   // driver: presents pixels from the pending queue, predicts each at its transfer
   always @(posedge clock) begin : pixel_driver
      pixel_type next_px;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_pixels.push_back(convert_pixel({req_red_in, req_green_in, req_blue_in}));
         end
         // the payload may only move when nothing is held under stall
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               next_px = pending_pixels.pop_front();
               req_red_in <= next_px.red;
               req_green_in <= next_px.green;
               req_blue_in <= next_px.blue;
               req_valid <= 1'b1;
               gap_left <= draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks every result transfer against the oldest prediction, then may stall a while
   always @(posedge clock) begin : pixel_monitor
      pixel_type got;
      pixel_type want;
      int        hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         got = {rsp_red_out, rsp_green_out, rsp_blue_out};
         if (predicted_pixels.size() == 0) begin
            if (error_count < 10) begin
               $display("%0t: unexpected pixel %h %h %h", $realtime, got.red, got.green,
                        got.blue);
            end
            error_count++;
         end else begin
            want = predicted_pixels.pop_front();
            for (int f = 0; f < 3; f++) begin
               if (got[f*CHAN_W +: CHAN_W] !== want[f*CHAN_W +: CHAN_W]) begin
                  if (error_count < 10) begin
                     $display("%0t: %s mismatch, expected %0d got %0d", $realtime,
                              field_name[f], want[f*CHAN_W +: CHAN_W],
                              got[f*CHAN_W +: CHAN_W]);
                  end
                  error_count++;
               end
            end
         end
         hold = draw_wait();
         stall_left <= hold;
         rsp_stall <= (hold != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                kind;
      int                r;
      int                g;
      int                b;
      int                v;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset registers: luminosity on all three rows
      queue_pixel(0, 0, 0);
      queue_pixel(255, 255, 255);
      queue_pixel(255, 0, 0);
      queue_pixel(0, 255, 0);
      queue_pixel(0, 0, 255);
      queue_pixel(170, 85, 51);
      wait_drained();

      // unmapped index must not touch any row
      write_reg(CSR_INDEX_W'(CSR_ROW_BLUE + 2), ROW_FULL);
      queue_pixel(255, 255, 255);
      queue_pixel(128, 64, 32);
      wait_drained();

      // channel average
      write_mode(MODE_AVERAGE);
      queue_pixel(255, 255, 255);
      queue_pixel(0, 0, 0);
      queue_pixel(2, 1, 0);
      queue_pixel(255, 254, 0);
      wait_drained();

      // lightness, then the unused mode code which acts the same
      write_mode(MODE_LIGHT);
      queue_pixel(255, 0, 0);
      queue_pixel(1, 0, 0);
      queue_pixel(3, 200, 9);
      wait_drained();
      write_mode(MODE_W'(MODE_LIGHT + 1));
      queue_pixel(255, 0, 0);
      queue_pixel(7, 100, 50);
      wait_drained();

      // sepia toning, saturating on bright input
      write_mode(MODE_MATRIX);
      write_reg(CSR_ROW_RED, SEPIA_RED);
      write_reg(CSR_ROW_GREEN, SEPIA_GREEN);
      write_reg(CSR_ROW_BLUE, SEPIA_BLUE);
      queue_pixel(255, 255, 255);
      queue_pixel(100, 150, 200);
      queue_pixel(0, 0, 0);
      wait_drained();

      // largest coefficients everywhere: full saturation on bright input
      write_reg(CSR_ROW_RED, ROW_FULL);
      write_reg(CSR_ROW_GREEN, ROW_FULL);
      write_reg(CSR_ROW_BLUE, ROW_FULL);
      queue_pixel(255, 255, 255);
      queue_pixel(1, 0, 0);
      wait_drained();

      // all-zero matrix
      write_reg(CSR_ROW_RED, ROW_ZERO);
      write_reg(CSR_ROW_GREEN, ROW_ZERO);
      write_reg(CSR_ROW_BLUE, ROW_ZERO);
      queue_pixel(255, 255, 255);
      wait_drained();

      // random phases, each with fresh registers; every mode code comes up twice
      for (int phase = 0; phase < PHASES; phase++) begin
         calm = ($urandom_range(0, 3) == 0);
         write_mode(MODE_W'(phase % 4));
         write_reg(CSR_ROW_RED, pick_row());
         write_reg(CSR_ROW_GREEN, pick_row());
         write_reg(CSR_ROW_BLUE, pick_row());
         if ($urandom_range(0, 1) != 0) begin
            write_reg(CSR_INDEX_W'(CSR_ROW_BLUE + 1 + $urandom_range(0, 3)),
                      ROW_W'({$urandom(), $urandom()}));
         end
         repeat (PIXELS_PER_PHASE) begin
            kind = $urandom_range(0, 7);
            case (kind)
               0: begin
                  // corners of the color cube
                  r = $urandom_range(0, 1) * 255;
                  g = $urandom_range(0, 1) * 255;
                  b = $urandom_range(0, 1) * 255;
               end
               1: begin
                  v = $urandom_range(0, 255);
                  r = v;
                  g = v;
                  b = v;
               end
               2: begin
                  r = $urandom_range(0, 3);
                  g = $urandom_range(0, 3);
                  b = $urandom_range(0, 3);
               end
               default: begin
                  r = $urandom_range(0, 255);
                  g = $urandom_range(0, 255);
                  b = $urandom_range(0, 255);
               end
            endcase
            queue_pixel(r, g, b);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && predicted_pixels.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
